### rtl/blm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blm_pkg;

  // Width of the sense voltage and of the stored maximum.
  localparam int unsigned VOLTAGE_BITS = 12;
  localparam int unsigned FULL_BITS    = 11;
  localparam int unsigned PCT_BITS     = 7;
  localparam int unsigned TICK_BITS    = 8;
  localparam int unsigned CFG_BITS     = 12;

  // Serial divider: the dividend is (v - 1500) * 100, below 50000.
  localparam int unsigned NUM_BITS = 16;
  localparam int unsigned DIV_BITS = 9;
  localparam int unsigned CNT_BITS = $clog2(NUM_BITS);

  localparam logic [VOLTAGE_BITS-1:0] V_MIN_MV       = VOLTAGE_BITS'(1500);
  localparam logic [VOLTAGE_BITS-1:0] CAL_TRIGGER_MV = VOLTAGE_BITS'(1900);
  localparam logic [FULL_BITS-1:0]    FULL_DEFAULT_MV = FULL_BITS'(2000);
  localparam logic [PCT_BITS-1:0]     PCT_FULL       = PCT_BITS'(100);
  localparam logic [PCT_BITS-1:0]     HEAT_PERCENT   = PCT_BITS'(50);
  localparam logic [PCT_BITS-1:0]     RED_PERCENT    = PCT_BITS'(20);
  localparam logic [TICK_BITS-1:0]    TICK_MAX       = '1;

  localparam logic [11:0] LOW_VOLTAGE_RESET   = 12'd1600;
  localparam logic [7:0]  WARN_INTERVAL_RESET = 8'd9;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_LOW_VOLTAGE   = 1'b0,
    REG_WARN_INTERVAL = 1'b1
  } reg_idx_e;

  // Item commands.
  typedef enum logic [0:0] {
    CMD_SAMPLE    = 1'b0,
    CMD_RESET_CAL = 1'b1
  } cmd_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_DONE = 2'd2
  } state_e;

endpackage

`default_nettype wire

### rtl/blm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface blm_in_if;
  import blm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [VOLTAGE_BITS-1:0] voltage_mv;
  logic                    training_active;

  modport source (output valid, output cmd, output voltage_mv, output training_active,
                  input ready);
  modport sink (input valid, input cmd, input voltage_mv, input training_active,
                output ready);
endinterface

`default_nettype wire

### rtl/blm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface blm_out_if;
  import blm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PCT_BITS-1:0]  percent;
  logic                 low_battery;
  logic                 warn_pulse;
  logic                 calibrated;
  logic [FULL_BITS-1:0] full_scale_mv;
  logic                 heat_allowed;
  logic                 red_light_allowed;

  modport source (output valid, output percent, output low_battery, output warn_pulse,
                  output calibrated, output full_scale_mv, output heat_allowed,
                  output red_light_allowed, input ready);
  modport sink (input valid, input percent, input low_battery, input warn_pulse,
                input calibrated, input full_scale_mv, input heat_allowed,
                input red_light_allowed, output ready);
endinterface

`default_nettype wire

### rtl/battery_level_monitor.sv
// Timing: a reset command or a sample outside the ramp goes straight to the result state, so a
// result can be taken in the cycle after acceptance; a sample on the ramp first runs the divider
// steps in the divide state, then shows the result. One item at a time: no new item is taken
// until the result is delivered. A 16-step restoring divider maps voltage to percent.
// Reset (rst_ni low, asynchronous) restores the registers to 1600 mV and 9 samples,
// clears calibration, low state, tick count and percent, and sets full scale to 2000 mV.
`timescale 1ns / 1ps
`default_nettype none

module battery_level_monitor (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [blm_pkg::CFG_BITS-1:0] cfg_data_i,
  blm_in_if.sink                      sample_i,
  blm_out_if.source                   result_o
);
  import blm_pkg::*;

  state_e state_q, state_d;

  logic [11:0]               low_mv_q;
  logic [7:0]                warn_int_q;
  logic [VOLTAGE_BITS-1:0]   max_q;
  logic [FULL_BITS-1:0]      full_q;
  logic                      cal_q;
  logic                      low_q;
  logic [TICK_BITS-1:0]      tick_q;
  logic [PCT_BITS-1:0]       pct_q;
  logic                      warn_q;

  logic [NUM_BITS-1:0]       num_q;
  logic [DIV_BITS-1:0]       rem_q;
  logic [DIV_BITS-1:0]       dvs_q;
  logic [PCT_BITS-1:0]       quo_q;
  logic [CNT_BITS-1:0]       cnt_q;

  logic accept, deliver, is_sample, need_div;

  assign accept    = sample_i.valid && sample_i.ready;
  assign deliver   = result_o.valid && result_o.ready;
  assign is_sample = (sample_i.cmd == CMD_SAMPLE);

  // Calibration update for the incoming sample.
  logic [VOLTAGE_BITS-1:0] v;
  logic                    new_max;
  logic [VOLTAGE_BITS-1:0] max_d;
  logic [FULL_BITS-1:0]    full_d;
  logic                    cal_d;
  logic [VOLTAGE_BITS-1:0] full_ext;

  assign v = sample_i.voltage_mv;

  always_comb begin
    new_max = (v > max_q);
    max_d   = max_q;
    full_d  = full_q;
    cal_d   = cal_q;
    if (new_max) begin
      max_d = v;
      if (v >= CAL_TRIGGER_MV) begin
        cal_d = 1'b1;
        if (v > VOLTAGE_BITS'(FULL_DEFAULT_MV)) begin
          full_d = FULL_DEFAULT_MV;
        end else begin
          full_d = v[FULL_BITS-1:0];
        end
      end
    end
  end

  assign full_ext = VOLTAGE_BITS'(full_d);
  assign need_div = (v > V_MIN_MV) && (v < full_ext);

  // Dividend (v - 1500) * 100 and divisor full - 1500 for the ramp.
  logic [DIV_BITS-1:0] span;
  logic [NUM_BITS-1:0] span_w;
  logic [NUM_BITS-1:0] num_init;
  logic [DIV_BITS-1:0] dvs_init;

  assign span     = DIV_BITS'(v - V_MIN_MV);
  assign span_w   = NUM_BITS'(span);
  assign num_init = (span_w << 6) + (span_w << 5) + (span_w << 2);
  assign dvs_init = DIV_BITS'(full_ext - V_MIN_MV);

  // Low state and warning tick for the incoming sample.
  logic                 low_d;
  logic [TICK_BITS-1:0] tick_a, tick_b, tick_d;
  logic                 warn_d;

  always_comb begin
    low_d  = low_q;
    tick_a = tick_q;
    if (v > low_mv_q) begin
      low_d  = 1'b0;
      tick_a = '0;
    end else if (!low_q) begin
      low_d  = 1'b1;
      tick_a = '0;
    end
    tick_b = (tick_a < TICK_MAX) ? tick_a + 1'b1 : tick_a;
    tick_d = tick_b;
    warn_d = 1'b0;
    if (low_d && (tick_b >= warn_int_q)) begin
      warn_d = !sample_i.training_active;
      tick_d = '0;
    end
  end

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  logic [DIV_BITS:0]   r_sh;
  logic                q_bit;
  logic [DIV_BITS-1:0] rem_d;
  logic [PCT_BITS-1:0] quo_d;

  always_comb begin
    r_sh  = {rem_q, num_q[NUM_BITS-1]};
    q_bit = (r_sh >= {1'b0, dvs_q});
    rem_d = q_bit ? DIV_BITS'(r_sh - {1'b0, dvs_q}) : r_sh[DIV_BITS-1:0];
    quo_d = {quo_q[PCT_BITS-2:0], q_bit};
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (is_sample && need_div) ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (deliver) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    sample_i.ready = 1'b0;
    result_o.valid = 1'b0;
    unique case (state_q)
      ST_IDLE: sample_i.ready = 1'b1;
      ST_DONE: result_o.valid = 1'b1;
      default: ;
    endcase
  end

  assign result_o.percent           = pct_q;
  assign result_o.low_battery       = low_q;
  assign result_o.warn_pulse        = warn_q;
  assign result_o.calibrated        = cal_q;
  assign result_o.full_scale_mv     = full_q;
  assign result_o.heat_allowed      = (pct_q >= HEAT_PERCENT);
  assign result_o.red_light_allowed = (pct_q >= RED_PERCENT);

  // Control and block state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      low_mv_q   <= LOW_VOLTAGE_RESET;
      warn_int_q <= WARN_INTERVAL_RESET;
      max_q      <= '0;
      full_q     <= FULL_DEFAULT_MV;
      cal_q      <= 1'b0;
      low_q      <= 1'b0;
      tick_q     <= '0;
      pct_q      <= '0;
      warn_q     <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_LOW_VOLTAGE:   low_mv_q   <= cfg_data_i[11:0];
          REG_WARN_INTERVAL: warn_int_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (is_sample) begin
          max_q  <= max_d;
          full_q <= full_d;
          cal_q  <= cal_d;
          low_q  <= low_d;
          tick_q <= tick_d;
          warn_q <= warn_d;
          cnt_q  <= CNT_BITS'(NUM_BITS - 1);
          if (v <= V_MIN_MV) begin
            pct_q <= '0;
          end else if (!need_div) begin
            pct_q <= PCT_FULL;
          end
        end else begin
          max_q  <= '0;
          full_q <= FULL_DEFAULT_MV;
          cal_q  <= 1'b0;
          warn_q <= 1'b0;
        end
      end
      if (state_q == ST_DIV) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          pct_q <= quo_d;
        end
      end
    end
  end

  // Divider shift registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q <= num_init;
      dvs_q <= dvs_init;
      rem_q <= '0;
      quo_q <= '0;
    end else if (state_q == ST_DIV) begin
      num_q <= num_q << 1;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

endmodule

`default_nettype wire

### rtl/blm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module blm_props (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [blm_pkg::PCT_BITS-1:0]  percent,
  input wire logic                          calibrated,
  input wire logic [blm_pkg::FULL_BITS-1:0] full_scale_mv,
  input wire logic                          heat_allowed,
  input wire logic                          red_light_allowed
);
  import blm_pkg::*;

  // One item at a time: no new item is taken while a result is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid && !out_ready |=> $stable(percent) && $stable(full_scale_mv))
    else $error("result changed while stalled");

  // Percent stays in range and the permissions nest.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid |-> (percent <= PCT_FULL) && (!heat_allowed || red_light_allowed))
    else $error("percent or permissions out of range");

  // Full scale is the default until calibrated, then within the learned window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid |-> (calibrated || full_scale_mv == FULL_DEFAULT_MV) &&
                    (full_scale_mv >= FULL_BITS'(1900)) &&
                    (full_scale_mv <= FULL_DEFAULT_MV))
    else $error("full scale inconsistent with calibration");

endmodule

bind battery_level_monitor blm_props u_blm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready          (sample_i.ready),
  .out_valid         (result_o.valid),
  .out_ready         (result_o.ready),
  .percent           (result_o.percent),
  .calibrated        (result_o.calibrated),
  .full_scale_mv     (result_o.full_scale_mv),
  .heat_allowed      (result_o.heat_allowed),
  .red_light_allowed (result_o.red_light_allowed)
);

`default_nettype wire

### bench/blm_checker.sv
`timescale 1ns / 1ps

// Watches the sample and result channels and the register port, predicts each
// result of the battery monitor and compares it with what the block returns.
module blm_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [blm_pkg::CFG_BITS-1:0] cfg_data_i,
  blm_in_if                                 sample_mon,
  blm_out_if                                result_mon,
  output int unsigned                       errors_o,
  output int unsigned                       pending_o
);
  import blm_pkg::*;

  // One predicted result item.
  typedef struct packed {
    logic [PCT_BITS-1:0]  percent;
    logic                 low_battery;
    logic                 warn_pulse;
    logic                 calibrated;
    logic [FULL_BITS-1:0] full_scale_mv;
    logic                 heat_allowed;
    logic                 red_light_allowed;
  } gauge_t;

  gauge_t readings_q[$];

  // Register copies.
  logic [VOLTAGE_BITS-1:0] lim_mv;
  logic [TICK_BITS-1:0]    warn_every;

  // Tracked block state.
  logic [VOLTAGE_BITS-1:0] peak_mv;
  logic [FULL_BITS-1:0]    full_mv;
  logic                    is_cal;
  logic                    is_low;
  logic [TICK_BITS-1:0]    ticks;
  logic [PCT_BITS-1:0]     pct_now;

  // Linear map from the empty point up to the full point, truncating.
  function automatic logic [PCT_BITS-1:0] charge_pct(input logic [VOLTAGE_BITS-1:0] v,
                                                     input logic [FULL_BITS-1:0] full);
    int unsigned num;
    int unsigned den;
    if (v <= V_MIN_MV) return '0;
    if (v >= full || full <= V_MIN_MV) return PCT_FULL;
    num = (32'(v) - 32'(V_MIN_MV)) * 32'(PCT_FULL);
    den = 32'(full) - 32'(V_MIN_MV);
    return PCT_BITS'(num / den);
  endfunction

  // Applies one item to the tracked state and returns the result it causes.
  task automatic step_gauge(input cmd_e op, input logic [VOLTAGE_BITS-1:0] v,
                            input logic train, output gauge_t res);
    logic                 warn;
    logic [FULL_BITS-1:0] full_use;
    warn = 1'b0;
    if (op == CMD_RESET_CAL) begin
      peak_mv = '0;
      full_mv = FULL_DEFAULT_MV;
      is_cal  = 1'b0;
    end else begin
      if (v > peak_mv) begin
        peak_mv = v;
        if (peak_mv >= CAL_TRIGGER_MV) begin
          full_mv = (peak_mv > VOLTAGE_BITS'(FULL_DEFAULT_MV)) ? FULL_DEFAULT_MV
                                                               : peak_mv[FULL_BITS-1:0];
          is_cal  = 1'b1;
        end
      end
      pct_now = charge_pct(v, is_cal ? full_mv : FULL_DEFAULT_MV);

      // Low state has no hysteresis; the tick count restarts on entry and on exit.
      if (v > lim_mv) begin
        ticks  = '0;
        is_low = 1'b0;
      end else if (!is_low) begin
        is_low = 1'b1;
        ticks  = '0;
      end
      if (ticks != TICK_MAX) ticks = ticks + 1'b1;
      if (ticks >= warn_every && is_low) begin
        warn  = !train;
        ticks = '0;
      end
    end
    full_use = is_cal ? full_mv : FULL_DEFAULT_MV;

    res.percent           = pct_now;
    res.low_battery       = is_low;
    res.warn_pulse        = warn;
    res.calibrated        = is_cal;
    res.full_scale_mv     = full_use;
    res.heat_allowed      = (pct_now >= HEAT_PERCENT);
    res.red_light_allowed = (pct_now >= RED_PERCENT);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors_o++;
      if (errors_o <= 10) $display("MISMATCH %s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // Prediction on accepted samples, comparison on accepted results.
  always @(posedge clk_i or negedge rst_ni) begin : track
    gauge_t want;
    if (!rst_ni) begin
      lim_mv     = LOW_VOLTAGE_RESET;
      warn_every = WARN_INTERVAL_RESET;
      peak_mv    = '0;
      full_mv    = FULL_DEFAULT_MV;
      is_cal     = 1'b0;
      is_low     = 1'b0;
      ticks      = '0;
      pct_now    = '0;
      readings_q.delete();
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        if (reg_idx_e'(cfg_idx_i) == REG_LOW_VOLTAGE) begin
          lim_mv = cfg_data_i[VOLTAGE_BITS-1:0];
        end else begin
          warn_every = cfg_data_i[TICK_BITS-1:0];
        end
      end

      // A result can never belong to the item accepted at the same edge.
      if (result_mon.valid && result_mon.ready) begin
        if (readings_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("MISMATCH: result item with no prediction waiting");
        end else begin
          want = readings_q.pop_front();
          check_field("percent", want.percent, result_mon.percent);
          check_field("low_battery", want.low_battery, result_mon.low_battery);
          check_field("warn_pulse", want.warn_pulse, result_mon.warn_pulse);
          check_field("calibrated", want.calibrated, result_mon.calibrated);
          check_field("full_scale_mv", want.full_scale_mv, result_mon.full_scale_mv);
          check_field("heat_allowed", want.heat_allowed, result_mon.heat_allowed);
          check_field("red_light_allowed", want.red_light_allowed,
                      result_mon.red_light_allowed);
        end
      end

      if (sample_mon.valid && sample_mon.ready) begin
        step_gauge(cmd_e'(sample_mon.cmd), sample_mon.voltage_mv,
                   sample_mon.training_active, want);
        readings_q.push_back(want);
      end
      pending_o = readings_q.size();
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

// Drives samples and register writes into the battery monitor, stalls the
// result side at random and reports the verdict from the checker.
module tb_top;
  import blm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NUM_PHASES  = 7;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [CFG_BITS-1:0] cfg_data_i;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          steady = 1'b0;

  blm_in_if  sample_if ();
  blm_out_if result_if ();

  battery_level_monitor uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_if),
    .result_o   (result_if)
  );

  blm_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_mon (sample_if),
    .result_mon (result_if),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none in a steady stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Voltages cluster on the ramp and around the low threshold.
  function automatic logic [VOLTAGE_BITS-1:0] pick_volt(input int unsigned lim);
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      v = $urandom_range(1450, 2050);
    end else if (r < 65) begin
      v = int'(lim) + int'($urandom_range(0, 6)) - 3;
    end else if (r < 75) begin
      case ($urandom_range(0, 5))
        0:       v = 0;
        1:       v = 4095;
        2:       v = 1500;
        3:       v = 1900;
        4:       v = 2000;
        default: v = 1501;
      endcase
    end else begin
      v = $urandom_range(0, 4095);
    end
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return VOLTAGE_BITS'(v);
  endfunction

  // Result side: ready drops for random stretches.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Offers one item after a random gap and holds it until it is accepted.
  task automatic send_item(input cmd_e op, input logic [VOLTAGE_BITS-1:0] v,
                           input logic train);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      sample_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    sample_if.valid           <= 1'b1;
    sample_if.cmd             <= op;
    sample_if.voltage_mv      <= v;
    sample_if.training_active <= train;
    do @(posedge clk_i); while (!(sample_if.valid && sample_if.ready));
  endtask

  // Stops offering items and waits for every predicted result.
  task automatic settle();
    @(negedge clk_i);
    sample_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_BITS'(value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    int unsigned lim_tab [NUM_PHASES];
    int unsigned warn_tab [NUM_PHASES];
    int unsigned len_tab [NUM_PHASES];
    int unsigned lim;
    int unsigned warn;
    cmd_e        op;

    lim_tab  = '{1600, 4095, 0, 1750, 4095, 1650, 0};
    warn_tab = '{9, 1, 255, 0, 255, 3, 0};
    len_tab  = '{140, 140, 140, 140, 300, 140, 130};

    sample_if.valid           = 1'b0;
    sample_if.cmd             = CMD_SAMPLE;
    sample_if.voltage_mv      = '0;
    sample_if.training_active = 1'b0;
    cfg_we_i                  = 1'b0;
    cfg_idx_i                 = REG_LOW_VOLTAGE;
    cfg_data_i                = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items on the reset register values. A reset command before any
    // sample reads zero percent; the extremes follow.
    send_item(CMD_RESET_CAL, 12'd0, 1'b0);
    send_item(CMD_SAMPLE, 12'd0, 1'b0);
    send_item(CMD_SAMPLE, 12'd4095, 1'b1);
    // A reset command repeats the last percent and clears calibration.
    send_item(CMD_RESET_CAL, 12'd4095, 1'b1);
    // Ramp ends and the learning of the full point below and at the cap.
    send_item(CMD_SAMPLE, 12'd1500, 1'b0);
    send_item(CMD_SAMPLE, 12'd1501, 1'b0);
    send_item(CMD_SAMPLE, 12'd1750, 1'b0);
    send_item(CMD_SAMPLE, 12'd1899, 1'b0);
    send_item(CMD_SAMPLE, 12'd1900, 1'b0);
    send_item(CMD_SAMPLE, 12'd1950, 1'b0);
    send_item(CMD_RESET_CAL, 12'd1234, 1'b0);
    send_item(CMD_SAMPLE, 12'd1800, 1'b0);
    send_item(CMD_SAMPLE, 12'd2100, 1'b0);
    // A run of low samples at and under the threshold; the warning comes
    // while training is set.
    for (int k = 0; k < 9; k++) begin
      send_item(CMD_SAMPLE, VOLTAGE_BITS'(1600 - k), (k == 8));
    end
    send_item(CMD_SAMPLE, 12'd1601, 1'b0);
    send_item(CMD_SAMPLE, 12'd1600, 1'b0);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      lim  = lim_tab[ph];
      warn = warn_tab[ph];
      if (ph == NUM_PHASES - 1) begin
        lim  = $urandom_range(1500, 2000);
        warn = $urandom_range(1, 255);
      end
      write_reg(REG_LOW_VOLTAGE, lim);
      write_reg(REG_WARN_INTERVAL, warn);
      steady = (ph == 3);
      for (int k = 0; k < len_tab[ph]; k++) begin
        op = ($urandom_range(0, 19) == 0) ? CMD_RESET_CAL : CMD_SAMPLE;
        send_item(op, pick_volt(lim), ($urandom_range(0, 2) == 0));
      end
    end
    steady = 1'b0;

    settle();
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
